[rtl/ipfs_pkg.sv]
package ipfs_pkg;

   // Batch geometry
   localparam int PACKETS_PER_BATCH = 32;
   localparam int PKT_CNT_W = (PACKETS_PER_BATCH > 1) ? $clog2(PACKETS_PER_BATCH) : 1;

   // Rate generator: 44.1 kHz frames per 8 kHz packet as 5 + 41/80
   localparam int PHASE_W = 7;
   localparam logic [PHASE_W-1:0] PHASE_STEP = PHASE_W'(41);
   localparam logic [PHASE_W-1:0] PHASE_MOD  = PHASE_W'(80);
   localparam int BASE_FRAMES     = 5;
   localparam int BYTES_PER_FRAME = 12;

   // Field widths
   localparam int CFG_W       = 13;
   localparam int PTR_W       = 12;
   localparam int POS_W       = 13;
   localparam int OFFSET_W    = 12;
   localparam int LENGTH_W    = 7;
   localparam int FRAMES_W    = 8;
   localparam int PKT_FRAME_W = 3;
   localparam int TOTAL_W     = $clog2(PACKETS_PER_BATCH * (BASE_FRAMES + 1) + 1);
   localparam int SUM_W       = ((TOTAL_W > POS_W) ? TOTAL_W : POS_W) + 1;

   localparam logic [LENGTH_W-1:0] LEN_SHORT = LENGTH_W'(BASE_FRAMES * BYTES_PER_FRAME);
   localparam logic [LENGTH_W-1:0] LEN_LONG  = LENGTH_W'((BASE_FRAMES + 1) * BYTES_PER_FRAME);

   // Register map
   localparam int CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BUFFER_FRAMES = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD_FRAMES = 1'd1;
   localparam logic [CFG_W-1:0] BUFFER_FRAMES_RST = CFG_W'(3072);
   localparam logic [CFG_W-1:0] PERIOD_FRAMES_RST = CFG_W'(384);

   // Controller to datapath commands
   typedef struct packed {
      logic clear;      // reset op: clear phase, pointer, period position
      logic start;      // open a batch: latch play flag, rewind sizing walk
      logic size_step;  // advance sizing walk by one packet
      logic commit;     // update pointer and period, rewind walk for emission
      logic emit;       // load one packet result into the output register
      logic last;       // the emitted packet closes the batch
   } ipfs_cmd_type;

   typedef struct packed {
      logic out_free;   // output register can take a result this cycle
   } ipfs_sts_type;

   function automatic logic phase_wraps(input logic [PHASE_W-1:0] ph);
      return (ph + PHASE_STEP) >= PHASE_MOD;
   endfunction

   function automatic logic [PHASE_W-1:0] phase_advance(input logic [PHASE_W-1:0] ph);
      logic [PHASE_W-1:0] sum;
      sum = ph + PHASE_STEP;
      return (sum >= PHASE_MOD) ? (sum - PHASE_MOD) : sum;
   endfunction

endpackage

[rtl/ipfs_ctrl.sv]
module ipfs_ctrl
   import ipfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_op,
   input  logic         req_enabled,
   input  logic         req_error,
   input  ipfs_sts_type sts,
   output ipfs_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SIZE   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   localparam logic [PKT_CNT_W-1:0] LAST_PKT = PKT_CNT_W'(PACKETS_PER_BATCH - 1);

   state_type            state_ff, state_in;
   logic [PKT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 accept;
   logic                 at_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign at_last    = (cnt_ff == LAST_PKT);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op) begin
                  cmd.clear = 1'b1;
               end else if (req_enabled && !req_error) begin
                  cmd.start = 1'b1;
                  cnt_in    = '0;
                  state_in  = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            cmd.size_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (at_last) begin
               cnt_in   = '0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            cnt_in     = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = at_last;
               cnt_in   = cnt_ff + 1'b1;
               if (at_last) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_size_to_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIZE) && at_last |=> (state_ff == ST_COMMIT))
      else $error("sizing walk did not end in commit");

   a_commit_to_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_EMIT) && (cnt_ff == '0))
      else $error("emission did not start at packet zero");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after last packet");

endmodule

[rtl/ipfs_dp.sv]
module ipfs_dp
   import ipfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wr_data,
   input  logic                  req_play,
   input  ipfs_cmd_type          cmd,
   output ipfs_sts_type          sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OFFSET_W-1:0]   rsp_offset,
   output logic [LENGTH_W-1:0]   rsp_length,
   output logic                  rsp_tlast,
   output logic [PTR_W-1:0]      rsp_read_start,
   output logic [FRAMES_W-1:0]   rsp_frames,
   output logic [PTR_W-1:0]      rsp_new_pointer,
   output logic                  rsp_elapsed,
   output logic                  rsp_silent
);

   logic [CFG_W-1:0]    buffer_frames_ff, period_frames_ff;
   logic [PHASE_W-1:0]  rate_phase_ff, rate_phase_in;
   logic [PTR_W-1:0]    ring_pointer_ff, ring_pointer_in;
   logic [POS_W-1:0]    period_position_ff, period_position_in;
   logic [PHASE_W-1:0]  walk_phase_ff, walk_phase_in;
   logic [TOTAL_W-1:0]  total_ff;
   logic                live_ff;
   logic [PTR_W-1:0]    start_ff, new_ptr_ff;
   logic                elapsed_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [FRAMES_W-1:0] frames_ff;
   logic                rsp_valid_ff;

   logic                  wraps;
   logic [PKT_FRAME_W-1:0] pkt_frames;
   logic [LENGTH_W-1:0]   pkt_len;
   logic [SUM_W-1:0]      ptr_sum, per_sum;
   logic [PTR_W-1:0]      ptr_next;
   logic [POS_W-1:0]      per_next;
   logic                  per_cross;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_frames_ff <= BUFFER_FRAMES_RST;
         period_frames_ff <= PERIOD_FRAMES_RST;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_BUFFER_FRAMES: buffer_frames_ff <= csr_wr_data;
            CSR_PERIOD_FRAMES: period_frames_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Per-packet sizing from the walk phase
   assign wraps      = phase_wraps(walk_phase_ff);
   assign pkt_frames = wraps ? PKT_FRAME_W'(BASE_FRAMES + 1) : PKT_FRAME_W'(BASE_FRAMES);
   assign pkt_len    = wraps ? LEN_LONG : LEN_SHORT;

   // Ring pointer and period position after the batch, single wrap each
   assign ptr_sum   = SUM_W'(ring_pointer_ff) + SUM_W'(total_ff);
   assign ptr_next  = (ptr_sum >= SUM_W'(buffer_frames_ff))
                      ? PTR_W'(ptr_sum - SUM_W'(buffer_frames_ff)) : PTR_W'(ptr_sum);
   assign per_sum   = SUM_W'(period_position_ff) + SUM_W'(total_ff);
   assign per_cross = (per_sum >= SUM_W'(period_frames_ff));
   assign per_next  = per_cross
                      ? POS_W'(per_sum - SUM_W'(period_frames_ff)) : POS_W'(per_sum);

   always_comb begin
      rate_phase_in      = rate_phase_ff;
      ring_pointer_in    = ring_pointer_ff;
      period_position_in = period_position_ff;
      walk_phase_in      = walk_phase_ff;
      if (cmd.clear) begin
         rate_phase_in      = '0;
         ring_pointer_in    = '0;
         period_position_in = '0;
      end
      if (cmd.start) begin
         walk_phase_in = rate_phase_ff;
      end
      if (cmd.size_step || cmd.emit) begin
         walk_phase_in = phase_advance(walk_phase_ff);
      end
      if (cmd.commit) begin
         // hold the end phase as state, rewind the walk for emission
         rate_phase_in = walk_phase_ff;
         walk_phase_in = rate_phase_ff;
         if (live_ff) begin
            ring_pointer_in    = ptr_next;
            period_position_in = per_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_phase_ff      <= '0;
         ring_pointer_ff    <= '0;
         period_position_ff <= '0;
         walk_phase_ff      <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rate_phase_ff      <= rate_phase_in;
         ring_pointer_ff    <= ring_pointer_in;
         period_position_ff <= period_position_in;
         walk_phase_ff      <= walk_phase_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Batch bookkeeping and output register
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         live_ff  <= req_play;
         total_ff <= '0;
      end
      if (cmd.size_step) begin
         total_ff <= total_ff + TOTAL_W'(pkt_frames);
      end
      if (cmd.commit) begin
         start_ff   <= ring_pointer_ff;
         new_ptr_ff <= live_ff ? ptr_next : ring_pointer_ff;
         elapsed_ff <= live_ff && per_cross;
         offset_ff  <= '0;
         frames_ff  <= '0;
      end
      if (cmd.emit) begin
         rsp_offset      <= offset_ff;
         rsp_length      <= pkt_len;
         rsp_tlast       <= cmd.last;
         rsp_read_start  <= start_ff;
         rsp_frames      <= frames_ff + FRAMES_W'(pkt_frames);
         rsp_new_pointer <= cmd.last ? new_ptr_ff : '0;
         rsp_elapsed     <= cmd.last && elapsed_ff;
         rsp_silent      <= !live_ff;
         offset_ff       <= offset_ff + OFFSET_W'(pkt_len);
         frames_ff       <= frames_ff + FRAMES_W'(pkt_frames);
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (rate_phase_ff < PHASE_MOD) && (walk_phase_ff < PHASE_MOD))
      else $error("rate phase left its modulus");

   a_emit_lands: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted packet not presented");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("emit overwrote a pending result");

endmodule

[rtl/iso_packet_frame_scheduler_unit.sv]
// Isochronous packet scheduler: an accepted batch walks the rate phase serially over its 32
// packets to size the batch, commits the ring pointer and period position when play_audio is
// set, then emits 32 packet transfers at one per cycle while the output is not stalled.
// A batch holds the input until its last packet is emitted, output stalls included.
// Reset ops and dropped batches are accepted without leaving idle and give no transfer.
// Synchronous reset clears the phase, pointer, period position and loads register defaults.
module iso_packet_frame_scheduler_unit
   import ipfs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wr_data,
   // batch events
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // [0] play_audio, [1] stream_enabled,
                                              // [2] transfer_error, [7:3] zero
   input  logic                  req_tuser,  // [0] op
   // packet results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [55:0]           rsp_tdata,  // [11:0] packet_offset, [18:12] packet_length,
                                              // [30:19] read_start, [38:31] batch_frames,
                                              // [50:39] new_pointer, [51] period_elapsed,
                                              // [55:52] zero
   output logic                  rsp_tlast,  // last_packet
   output logic                  rsp_tuser   // [0] silent
);

   ipfs_cmd_type cmd;
   ipfs_sts_type sts;

   logic [OFFSET_W-1:0] rsp_offset;
   logic [LENGTH_W-1:0] rsp_length;
   logic [PTR_W-1:0]    rsp_read_start;
   logic [FRAMES_W-1:0] rsp_frames;
   logic [PTR_W-1:0]    rsp_new_pointer;
   logic                rsp_elapsed;

   // Controller: decodes the event kind, sequences size, commit and emit passes
   ipfs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .req_enabled (req_tdata[1]),
      .req_error   (req_tdata[2]),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Datapath: rate phase, ring pointer, period counter and the output register
   ipfs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_addr        (csr_addr),
      .csr_wr_data     (csr_wr_data),
      .req_play        (req_tdata[0]),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_offset      (rsp_offset),
      .rsp_length      (rsp_length),
      .rsp_tlast       (rsp_tlast),
      .rsp_read_start  (rsp_read_start),
      .rsp_frames      (rsp_frames),
      .rsp_new_pointer (rsp_new_pointer),
      .rsp_elapsed     (rsp_elapsed),
      .rsp_silent      (rsp_tuser)
   );

   // Pack the result transfer, first field lowest
   assign rsp_tdata = {4'b0000, rsp_elapsed, rsp_new_pointer, rsp_frames,
                       rsp_read_start, rsp_length, rsp_offset};

endmodule
